@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL; they compile to nothing under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expr must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

@@ hw/rtl/ssa_pkg.sv @@
// Types and constants of the series statistics accumulator.
`default_nettype none

package ssa_pkg;

	localparam int SMP_W  = 16;
	localparam int CNT_W  = 16;
	localparam int SUM_W  = 32;
	localparam int SQ_W   = 48;
	localparam int SQR_W  = 32;
	localparam int VAR_W  = 31;
	localparam int PROD_W = 64;

	localparam int QDEPTH = 4;

	localparam logic FUNC_ADD    = 1'b0;
	localparam logic FUNC_REPORT = 1'b1;

	localparam logic [1:0] ST_ACCEPTED = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_STATS    = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	typedef logic signed [SMP_W-1:0] q88_t;

	typedef struct packed {
		logic func;
		q88_t sample;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [CNT_W-1:0] sample_total;
		q88_t             mean_value;
		logic [VAR_W-1:0] variance_value;
		q88_t             min_value;
		q88_t             max_value;
		logic [SMP_W-1:0] spread_value;
	} out_item_t;

	typedef enum logic {
		OP_ADD,
		OP_REPORT
	} op_t;

	// decoded request as held in the queue, square already formed
	typedef struct packed {
		op_t              op;
		q88_t             sample;
		logic [SQR_W-1:0] square;
	} q_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/ssa_chan_if.sv @@
// Valid/ready channel carrying one payload of type T.
`default_nettype none

interface ssa_chan_if #(parameter type T = logic) ();

	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

@@ hw/rtl/ssa_divu.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module ssa_divu #(
	parameter int DVD_W = 32,
	parameter int DVS_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic [DVD_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DVD_W);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;

	logic [DVS_W:0] rem_sh;
	logic [DVS_W:0] rem_sub;
	logic           fits;

	assign rem_sh  = {rem_q, quo_q[DVD_W-1]};
	assign fits    = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
			quo_q  <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			// quotient bits shift in where dividend bits shift out
			quo_q  <= {quo_q[DVD_W-2:0], fits};
			rem_q  <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(DVD_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

@@ hw/rtl/ssa_front.sv @@
// Front end: takes requests, decodes them, squares the sample and queues them.
`default_nettype none

module ssa_front (
	input  logic             clk,
	input  logic             arst_n,
	ssa_chan_if.sink         sample_chan,
	output logic             q_valid,
	output ssa_pkg::q_item_t q_item,
	input  logic             q_ready
);

	import ssa_pkg::*;

	localparam int QPTR_W = $clog2(QDEPTH);

	q_item_t           fifo_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	q_item_t            entry;
	logic signed [31:0] square_s;
	logic               push;
	logic               pop;

	assign square_s     = sample_chan.data.sample * sample_chan.data.sample;
	assign entry.op     = (sample_chan.data.func == FUNC_REPORT) ? OP_REPORT : OP_ADD;
	assign entry.sample = sample_chan.data.sample;
	assign entry.square = SQR_W'(unsigned'(square_s));

	assign sample_chan.ready = fill_q != (QPTR_W+1)'(QDEPTH);
	assign push              = sample_chan.valid && sample_chan.ready;
	assign q_valid           = fill_q != '0;
	assign pop               = q_valid && q_ready;
	assign q_item            = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + (QPTR_W+1)'(1);
				2'b01:   fill_q <= fill_q - (QPTR_W+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/ssa_back.sv @@
// Back end: running totals, report sequencer and the result register.
`default_nettype none
`include "assert_macros.svh"

module ssa_back #(
	parameter int MAX_SAMPLES = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  ssa_pkg::q_item_t q_item,
	output logic             q_ready,
	ssa_chan_if.source       stats_chan
);

	import ssa_pkg::*;

	localparam int MUL_STEPS = SUM_W;
	localparam int MCNT_W    = $clog2(MUL_STEPS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_SUB,
		S_DIV
	} state_t;

	state_t                   state_q;
	logic                     res_valid_q;
	out_item_t                res_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]          sq_q;
	q88_t                     min_q;
	q88_t                     max_q;
	logic [2*CNT_W-1:0]       nsq_q;
	logic [PROD_W-1:0]        a_acc_q;
	logic [PROD_W-1:0]        a_mcand_q;
	logic [CNT_W-1:0]         a_mplier_q;
	logic [PROD_W-1:0]        b_acc_q;
	logic [PROD_W-1:0]        b_mcand_q;
	logic [SUM_W-1:0]         b_mplier_q;
	logic [MCNT_W-1:0]        mul_cnt_q;

	logic                     slot_free;
	logic                     pop;
	logic                     has_room;
	logic                     first;
	logic [SUM_W-1:0]         smp_ext;
	logic [SUM_W-1:0]         s1abs;
	logic [2*CNT_W-1:0]       nsq;
	logic [PROD_W-1:0]        diff;
	logic                     mean_start;
	logic                     mean_busy;
	logic [SUM_W-1:0]         mean_quo;
	logic [SUM_W-1:0]         mean_signed;
	logic                     var_start;
	logic                     var_busy;
	logic [PROD_W-1:0]        var_quo;
	logic [SMP_W-1:0]         spread;
	logic                     finish;
	logic                     load_res;
	out_item_t                res_d;

	assign slot_free = !res_valid_q || stats_chan.ready;
	assign q_ready   = (state_q == S_IDLE) && slot_free;
	assign pop       = q_valid && q_ready;
	assign has_room  = cnt_q < CNT_W'(MAX_SAMPLES);
	assign first     = cnt_q == '0;
	assign smp_ext   = {{(SUM_W-SMP_W){q_item.sample[SMP_W-1]}}, q_item.sample};
	assign s1abs     = sum_q[SUM_W-1] ? SUM_W'(unsigned'(-sum_q)) : SUM_W'(unsigned'(sum_q));
	assign nsq       = {{CNT_W{1'b0}}, cnt_q} * {{CNT_W{1'b0}}, cnt_q};
	// n*S2 >= S1^2 for any real series; clamp anyway
	assign diff      = (a_acc_q >= b_acc_q) ? (a_acc_q - b_acc_q) : '0;
	assign spread    = SMP_W'(unsigned'(max_q - min_q));

	assign mean_start  = pop && (q_item.op == OP_REPORT) && !first;
	assign var_start   = state_q == S_SUB;
	assign mean_signed = sum_q[SUM_W-1] ? (~mean_quo + SUM_W'(1)) : mean_quo;
	assign finish      = (state_q == S_DIV) && !var_busy && !mean_busy && slot_free;

	ssa_divu #(
		.DVD_W(SUM_W),
		.DVS_W(CNT_W)
	) u_mean_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mean_start),
		.dividend(s1abs),
		.divisor (cnt_q),
		.busy    (mean_busy),
		.quotient(mean_quo)
	);

	ssa_divu #(
		.DVD_W(PROD_W),
		.DVS_W(2*CNT_W)
	) u_var_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (var_start),
		.dividend(diff),
		.divisor (nsq_q),
		.busy    (var_busy),
		.quotient(var_quo)
	);

	// next result: add and empty report retire at pop, a full report at finish
	always_comb begin
		res_d    = '0;
		load_res = 1'b0;
		if (pop && (q_item.op == OP_ADD)) begin
			load_res = 1'b1;
			if (has_room) begin
				res_d.status       = ST_ACCEPTED;
				res_d.sample_total = cnt_q + CNT_W'(1);
			end else begin
				res_d.status       = ST_FULL;
				res_d.sample_total = cnt_q;
			end
		end else if (pop && first) begin
			load_res     = 1'b1;
			res_d.status = ST_EMPTY;
		end else if (finish) begin
			load_res             = 1'b1;
			res_d.status         = ST_STATS;
			res_d.sample_total   = cnt_q;
			res_d.mean_value     = q88_t'(mean_signed[SMP_W-1:0]);
			res_d.variance_value = var_quo[VAR_W-1:0];
			res_d.min_value      = min_q;
			res_d.max_value      = max_q;
			res_d.spread_value   = spread;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			cnt_q       <= '0;
			sum_q       <= '0;
			sq_q        <= '0;
			min_q       <= '0;
			max_q       <= '0;
			nsq_q       <= '0;
			a_acc_q     <= '0;
			a_mcand_q   <= '0;
			a_mplier_q  <= '0;
			b_acc_q     <= '0;
			b_mcand_q   <= '0;
			b_mplier_q  <= '0;
			mul_cnt_q   <= '0;
		end else begin
			res_valid_q <= load_res || (res_valid_q && !stats_chan.ready);
			if (load_res) begin
				res_q <= res_d;
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (q_item.op == OP_ADD) begin
							if (has_room) begin
								if (first || q_item.sample < min_q) begin
									min_q <= q_item.sample;
								end
								if (first || q_item.sample > max_q) begin
									max_q <= q_item.sample;
								end
								sum_q <= sum_q + signed'(smp_ext);
								sq_q  <= sq_q + {{(SQ_W-SQR_W){1'b0}}, q_item.square};
								cnt_q <= cnt_q + CNT_W'(1);
							end
						end else if (!first) begin
							nsq_q      <= nsq;
							a_acc_q    <= '0;
							a_mcand_q  <= {{(PROD_W-SQ_W){1'b0}}, sq_q};
							a_mplier_q <= cnt_q;
							b_acc_q    <= '0;
							b_mcand_q  <= {{(PROD_W-SUM_W){1'b0}}, s1abs};
							b_mplier_q <= s1abs;
							mul_cnt_q  <= '0;
							state_q    <= S_MUL;
						end
					end
				end
				S_MUL: begin
					// shift-add: n*S2 in a, S1*S1 in b
					a_acc_q    <= a_acc_q + (a_mplier_q[0] ? a_mcand_q : '0);
					a_mcand_q  <= a_mcand_q << 1;
					a_mplier_q <= a_mplier_q >> 1;
					b_acc_q    <= b_acc_q + (b_mplier_q[0] ? b_mcand_q : '0);
					b_mcand_q  <= b_mcand_q << 1;
					b_mplier_q <= b_mplier_q >> 1;
					mul_cnt_q  <= mul_cnt_q + MCNT_W'(1);
					if (mul_cnt_q == MCNT_W'(MUL_STEPS - 1)) begin
						state_q <= S_SUB;
					end
				end
				S_SUB: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign stats_chan.valid = res_valid_q;
	assign stats_chan.data  = res_q;

	`ASSERT_ALWAYS(a_cnt_cap, clk, arst_n, cnt_q <= CNT_W'(MAX_SAMPLES), "count above capacity")
	`ASSERT_ALWAYS(a_min_max, clk, arst_n, (cnt_q != '0) |-> (min_q <= max_q), "min above max")
	`ASSERT_ALWAYS(a_hold_cnt, clk, arst_n, (state_q != S_IDLE) |=> $stable(cnt_q), "count moved during report")
	`ASSERT_NEVER(a_var_range, clk, arst_n, finish && (var_quo[PROD_W-1:VAR_W] != '0), "variance overflow")
	`ASSERT_NEVER(a_idle_div, clk, arst_n, (state_q == S_IDLE) && var_busy, "variance divider busy while idle")

endmodule

`default_nettype wire

@@ hw/rtl/series_statistics_accumulator.sv @@
// Series statistics accumulator: running totals of Q8.8 samples and report on request.
//
// sample_chan (sink) takes requests {func, sample}: func add appends the sample, func report
// asks for mean, Q16.16 population variance, min, max and spread of the samples held.
// stats_chan (source) gives one result per request, in request order, with a status code.
// A request is taken on a clock edge where valid and ready are both high.
//
// Requests are decoded and squared in the front end and wait in a four-entry queue.
// Adds retire at one per cycle while the back end is idle and the result slot is free; an add
// result passes through the queue and then the result register. A report occupies the back
// end through 32 shift-add steps for n*S2 and S1*S1 (the mean divider runs alongside), a
// subtract state, then 64 steps of the variance divider, plus the load into the result register.
// While a report runs the queue still fills, and sample_chan drops ready when it is full.
// The result sits in an output register; when stats_chan is stalled the back end stops
// once it has a new result to load, and the queue then takes up the slack.
// arst_n clears the totals, the queue and the result register; sample_chan is ready as soon
// as reset is released.
`default_nettype none

module series_statistics_accumulator #(
	parameter int MAX_SAMPLES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	ssa_chan_if.sink   sample_chan,
	ssa_chan_if.source stats_chan
);

	import ssa_pkg::*;

	logic    q_valid;
	logic    q_ready;
	q_item_t q_item;

	ssa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_chan(sample_chan),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_ready    (q_ready)
	);

	ssa_back #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_ready   (q_ready),
		.stats_chan(stats_chan)
	);

endmodule

`default_nettype wire

@@ sim/series_statistics_accumulator_test.sv @@
// Self-checking testbench of the series statistics accumulator.
`timescale 1ns / 1ps

module series_statistics_accumulator_test;

	import ssa_pkg::*;

	localparam int SERIES_CAP = 256;
	localparam int RANDOM_REQUESTS = 530;

	// Tracks the running totals and holds the results still owed by the block.
	class stats_scoreboard;
		out_item_t         owed_q[$];
		int                mismatches;
		int                checked;
		int                taken;
		int                rejected;
		int                reported;
		int                empty_reports;
		logic [CNT_W-1:0]  held;
		int                sum_total;
		longint unsigned   square_total;
		q88_t              lowest;
		q88_t              highest;

		function new();
			owed_q.delete();
			mismatches = 0;
			checked = 0;
			taken = 0;
			rejected = 0;
			reported = 0;
			empty_reports = 0;
			held = '0;
			sum_total = 0;
			square_total = 0;
			lowest = '0;
			highest = '0;
		endfunction

		task log_mismatch(input string what, input longint unsigned got,
				input longint unsigned want);
			mismatches++;
			$display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
		endtask

		task compare_field(input string what, input longint unsigned got,
				input longint unsigned want);
			if (got !== want)
				log_mismatch(what, got, want);
		endtask

		function int pending();
			return owed_q.size();
		endfunction

		task note_request(input in_item_t req);
			out_item_t       res;
			q88_t            x;
			int              sq;
			int              mean;
			longint unsigned n;
			longint signed   s;
			longint unsigned s1abs;
			longint unsigned num;
			longint unsigned s1sq;
			longint unsigned diff;
			longint unsigned var_full;
			res = '0;
			x = req.sample;
			if (req.func == FUNC_ADD) begin
				if (held >= SERIES_CAP) begin
					res.status = ST_FULL;
					rejected++;
				end else begin
					sq = x * x;
					if (held == 0 || x < lowest)
						lowest = x;
					if (held == 0 || x > highest)
						highest = x;
					sum_total += x;
					square_total += longint'(sq);
					held++;
					res.status = ST_ACCEPTED;
					taken++;
				end
			end else if (held == 0) begin
				res.status = ST_EMPTY;
				empty_reports++;
			end else begin
				n = held;
				s = sum_total;
				s1abs = (s < 0) ? -s : s;
				num = n * square_total;
				s1sq = s1abs * s1abs;
				diff = (num >= s1sq) ? num - s1sq : 0;
				var_full = diff / (n * n);
				mean = sum_total / int'(held);
				res.status = ST_STATS;
				res.mean_value = q88_t'(mean);
				res.variance_value = var_full[VAR_W-1:0];
				res.min_value = lowest;
				res.max_value = highest;
				res.spread_value = highest - lowest;
				reported++;
			end
			res.sample_total = held;
			owed_q.push_back(res);
		endtask

		task check_result(input out_item_t got);
			out_item_t want;
			checked++;
			if (owed_q.size() == 0) begin
				log_mismatch("unrequested result", 64'(got.status), 0);
			end else begin
				want = owed_q.pop_front();
				compare_field("status", got.status, want.status);
				compare_field("sample_total", got.sample_total, want.sample_total);
				compare_field("mean_value", got.mean_value, want.mean_value);
				compare_field("variance_value", got.variance_value, want.variance_value);
				compare_field("min_value", got.min_value, want.min_value);
				compare_field("max_value", got.max_value, want.max_value);
				compare_field("spread_value", got.spread_value, want.spread_value);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	ssa_chan_if #(.T(in_item_t))  sample_chan ();
	ssa_chan_if #(.T(out_item_t)) stats_chan ();

	series_statistics_accumulator #(
		.MAX_SAMPLES(SERIES_CAP)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_chan (sample_chan),
		.stats_chan  (stats_chan)
	);

	stats_scoreboard sb;
	int calm_left = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// mostly short pauses, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll < 12)
			return 0;
		if (roll < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_request(input logic func, input q88_t smp);
		in_item_t req;
		int       gap;
		req.func = func;
		req.sample = smp;
		sample_chan.valid <= 1'b1;
		sample_chan.data <= req;
		do @(posedge clk); while (!sample_chan.ready);
		if (calm_left > 0) begin
			calm_left--;
			gap = 0;
		end else begin
			if ($urandom_range(0, 49) == 0)
				calm_left = $urandom_range(20, 60);
			gap = pick_gap();
		end
		if (gap > 0) begin
			sample_chan.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_chan.valid && sample_chan.ready)
				sb.note_request(sample_chan.data);
			if (stats_chan.valid && stats_chan.ready)
				sb.check_result(stats_chan.data);
		end
	end

	// result side backpressure
	initial begin
		int run;
		int stall;
		stats_chan.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 6);
			stats_chan.ready <= 1'b1;
			repeat (run) @(posedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				stats_chan.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin
		int   i;
		int   roll;
		logic func;
		q88_t smp;
		sb = new();
		sample_chan.valid <= 1'b0;
		sample_chan.data <= '0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// empty report, single sample, opposite extremes, mean truncation
		send_request(FUNC_REPORT, 16'sh8001);
		send_request(FUNC_ADD, 16'sh8000);
		send_request(FUNC_REPORT, 16'sh7fff);
		send_request(FUNC_ADD, 16'sd32767);
		send_request(FUNC_REPORT, 16'sh0000);
		send_request(FUNC_ADD, -16'sd1);
		send_request(FUNC_REPORT, 16'shffff);
		send_request(FUNC_ADD, 16'sd1);
		send_request(FUNC_ADD, 16'sd0);
		send_request(FUNC_ADD, 16'sh5555);
		send_request(FUNC_ADD, 16'shaaaa);
		send_request(FUNC_REPORT, 16'sh1234);
		send_request(FUNC_ADD, -16'sd3);
		send_request(FUNC_REPORT, 16'sh0001);

		// adds outnumber reports, so the store fills up and then rejects
		for (i = 0; i < RANDOM_REQUESTS; i++) begin
			func = ($urandom_range(0, 4) == 0) ? FUNC_REPORT : FUNC_ADD;
			roll = $urandom_range(0, 7);
			if (roll == 0)
				smp = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			else if (roll < 3)
				smp = q88_t'($urandom_range(0, 1023)) - 16'sd512;
			else
				smp = q88_t'($urandom_range(0, 65535));
			send_request(func, smp);
		end
		sample_chan.valid <= 1'b0;
		// let the monitor note the last request before waiting on the results
		@(posedge clk);

		while (sb.pending() > 0)
			@(posedge clk);
		repeat (150) @(posedge clk);

		$display("Sent %0d requests: %0d samples taken, %0d rejected at capacity,",
			sb.taken + sb.rejected + sb.reported + sb.empty_reports,
			sb.taken, sb.rejected);
		$display("%0d statistics reports, %0d empty reports; %0d results checked.",
			sb.reported, sb.empty_reports, sb.checked);
		if (sb.mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
